### design/blmee_pkg.sv
`default_nettype none
package blmee_pkg;

    localparam int MAX_BLOCK_FRAMES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF      = 16;

    localparam int X_W        = 18;
    localparam int FILT_W     = 32;
    localparam int SUMSQ_W    = 56;
    localparam int MAG_W      = 24;
    localparam int LEVEL_W    = 28;
    localparam int OUT_W      = 17;
    localparam int SMOOTH_W   = 32;
    localparam int FRAMES_W   = 21;
    localparam int A_W        = 29;
    localparam int B_W        = 35;
    localparam int P_W        = 64;
    localparam int DIV_STEPS  = 56;
    localparam int SQRT_STEPS = 28;
    localparam int STEP_W     = 6;
    localparam int SREM_W     = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_EN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SEL  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = 4'd7;

    localparam logic        RST_BAND_EN  = 1'b1;
    localparam logic        RST_PEAK_SEL = 1'b0;
    localparam logic [17:0] RST_FREQ     = 18'd5905;
    localparam logic [23:0] RST_DAMP     = 24'd186510;
    localparam logic [25:0] RST_GAIN     = 26'd655360;
    localparam logic [16:0] RST_SMOOTH   = 17'd65536;
    localparam logic        RST_RATE     = 1'b0;
    localparam logic [19:0] RST_FRAMES   = 20'd1470;

    localparam logic [16:0]        LEVEL_ONE = 17'd65536;
    localparam logic [MAG_W-1:0]   MAG_MAX   = '1;

    typedef enum logic [2:0] {
        MUL_RB,
        MUL_WH,
        MUL_WB,
        MUL_SQ,
        MUL_GAIN,
        MUL_SMOOTH
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     ch;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_h;
        logic     upd_bp;
        logic     upd_lp;
        logic     acc;
        logic     frame_tick;
        logic     div_init;
        logic     div_step;
        logic     root_init;
        logic     root_step;
        logic     lvl_peak;
        logic     lvl_zero;
        logic     lvl_root;
        logic     clamp;
        logic     smooth_inst;
        logic     smooth_upd;
        logic     decide;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_present;
        logic filt_en;
        logic last;
        logic peak_sel;
        logic count_zero;
        logic smooth_inst;
        logic send;
        logic out_busy;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return $signed(v[31:0]);
        end
    endfunction

endpackage
`default_nettype wire

### design/blmee_ctrl.sv
`default_nettype none
module blmee_ctrl
    import blmee_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    typedef enum logic [21:0] {
        S_IDLE      = 22'h000001,
        S_CHAN      = 22'h000002,
        S_F1        = 22'h000004,
        S_F2        = 22'h000008,
        S_F3        = 22'h000010,
        S_F4        = 22'h000020,
        S_F5        = 22'h000040,
        S_F6        = 22'h000080,
        S_SQ        = 22'h000100,
        S_ACC       = 22'h000200,
        S_FRAME     = 22'h000400,
        S_LEVEL     = 22'h000800,
        S_DIV       = 22'h001000,
        S_ROOT_INIT = 22'h002000,
        S_ROOT      = 22'h004000,
        S_ROOT_LOAD = 22'h008000,
        S_GAIN      = 22'h010000,
        S_CLAMP     = 22'h020000,
        S_SMOOTH    = 22'h040000,
        S_SMOOTH2   = 22'h080000,
        S_DECIDE    = 22'h100000,
        S_EMIT      = 22'h200000
    } state_t;

    state_t              state_reg, state_next;
    logic                ch_reg, ch_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MUL_RB;
        cmd.ch      = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    ch_next     = 1'b0;
                    state_next  = S_CHAN;
                end
            end
            S_CHAN:
            begin
                if (st.cur_present)
                begin
                    state_next = st.filt_en ? S_F1 : S_SQ;
                end
                else if (ch_reg)
                begin
                    state_next = S_FRAME;
                end
                else
                begin
                    ch_next = 1'b1;
                end
            end
            S_F1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RB;
                state_next  = S_F2;
            end
            S_F2:
            begin
                cmd.upd_h  = 1'b1;
                state_next = S_F3;
            end
            S_F3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WH;
                state_next  = S_F4;
            end
            S_F4:
            begin
                cmd.upd_bp = 1'b1;
                state_next = S_F5;
            end
            S_F5:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WB;
                state_next  = S_F6;
            end
            S_F6:
            begin
                cmd.upd_lp = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (ch_reg)
                begin
                    state_next = S_FRAME;
                end
                else
                begin
                    ch_next    = 1'b1;
                    state_next = S_CHAN;
                end
            end
            S_FRAME:
            begin
                cmd.frame_tick = 1'b1;
                state_next     = st.last ? S_LEVEL : S_IDLE;
            end
            S_LEVEL:
            begin
                if (st.peak_sel)
                begin
                    cmd.lvl_peak = 1'b1;
                    state_next   = S_GAIN;
                end
                else if (st.count_zero)
                begin
                    cmd.lvl_zero = 1'b1;
                    state_next   = S_GAIN;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = STEP_W'(DIV_STEPS - 1);
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ROOT_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                cnt_next      = STEP_W'(SQRT_STEPS - 1);
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ROOT_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_ROOT_LOAD:
            begin
                cmd.lvl_root = 1'b1;
                state_next   = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                if (st.smooth_inst)
                begin
                    cmd.smooth_inst = 1'b1;
                    state_next      = S_DECIDE;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_SMOOTH;
                    state_next  = S_SMOOTH2;
                end
            end
            S_SMOOTH2:
            begin
                cmd.smooth_upd = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!st.send)
                begin
                    state_next = S_IDLE;
                end
                else if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/blmee_dp.sv
`default_nettype none
module blmee_dp
    import blmee_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dp_cmd_t                       cmd,
    output dp_status_t                         st,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    input  wire logic                          left_present,
    input  wire logic                          right_present,
    input  wire logic                          last_in_block,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [OUT_W-1:0]                   level_value
);

    localparam int CNT_W = $clog2(2 * MAX_BLOCK_FRAMES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(2 * MAX_BLOCK_FRAMES);

    logic        band_en_reg, peak_sel_reg, rate_reg;
    logic [17:0] freq_reg;
    logic [23:0] damp_reg;
    logic [25:0] gain_reg;
    logic [16:0] smooth_coeff_reg;
    logic [19:0] frames_cfg_reg;

    logic signed [X_W-1:0]    xl_in, xr_in, xl_reg, xr_reg;
    logic                     pl_reg, pr_reg, last_reg;
    logic signed [FILT_W-1:0] lp_l_reg, bp_l_reg, lp_r_reg, bp_r_reg, h_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic [SUMSQ_W-1:0]       sum_reg;
    logic [MAG_W-1:0]         peak_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [SUMSQ_W-1:0]       q_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [SUMSQ_W-1:0]       rad_reg;
    logic [SREM_W-1:0]        srem_reg;
    logic [LEVEL_W-1:0]       root_reg, level_reg;
    logic [16:0]              target_reg;
    logic [SMOOTH_W-1:0]      smoothed_reg;
    logic [FRAMES_W-1:0]      frames_reg;
    logic [OUT_W-1:0]         last_emit_reg, out_level_reg;
    logic                     emitted_reg, send_reg, out_valid_reg;

    logic signed [X_W-1:0]    x_cur;
    logic signed [FILT_W-1:0] lp_cur, bp_cur, meas, hp_new, bp_new, lp_new;
    logic signed [P_W-1:0]    prod_sh;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic [FILT_W:0]          abs_v;
    logic [MAG_W-1:0]         mag;
    logic [SUMSQ_W:0]         sum_add;
    logic [CNT_W:0]           div_tr;
    logic                     div_bit;
    logic [SREM_W+1:0]        sq_tr, sq_trial;
    logic                     sq_bit;
    logic [16:0]              c_eff;
    logic signed [33:0]       smooth_d;
    logic [P_W-17:0]          gain_sh;
    logic [OUT_W-1:0]         outv;
    logic [19:0]              need;
    logic                     send_now;
    logic                     filt_clear;

    if (SAMPLE_BITS <= 17)
    begin : g_scale_up
        assign xl_in = X_W'(sample_left) <<< (17 - SAMPLE_BITS);
        assign xr_in = X_W'(sample_right) <<< (17 - SAMPLE_BITS);
    end
    else
    begin : g_scale_down
        assign xl_in = X_W'(sample_left >>> (SAMPLE_BITS - 17));
        assign xr_in = X_W'(sample_right >>> (SAMPLE_BITS - 17));
    end

    assign x_cur   = cmd.ch ? xr_reg : xl_reg;
    assign lp_cur  = cmd.ch ? lp_r_reg : lp_l_reg;
    assign bp_cur  = cmd.ch ? bp_r_reg : bp_l_reg;
    assign prod_sh = prod_reg >>> 16;
    assign hp_new  = sat32(66'(x_cur) - 66'(prod_sh) - 66'(lp_cur));
    assign bp_new  = sat32(66'(bp_cur) + 66'(prod_sh));
    assign lp_new  = sat32(66'(lp_cur) + 66'(prod_sh));

    assign meas  = band_en_reg ? bp_cur : FILT_W'(x_cur);
    assign abs_v = meas[FILT_W-1] ? -(FILT_W+1)'(meas) : (FILT_W+1)'(meas);
    assign mag   = (abs_v > (FILT_W+1)'(MAG_MAX)) ? MAG_MAX : abs_v[MAG_W-1:0];

    assign c_eff    = (smooth_coeff_reg > LEVEL_ONE) ? LEVEL_ONE : smooth_coeff_reg;
    assign smooth_d = $signed({2'b00, target_reg, 15'b0}) - $signed({2'b00, smoothed_reg});

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RB:
            begin
                mul_a = A_W'($signed({1'b0, damp_reg}));
                mul_b = B_W'(bp_cur);
            end
            MUL_WH:
            begin
                mul_a = A_W'($signed({1'b0, freq_reg}));
                mul_b = B_W'(h_reg);
            end
            MUL_WB:
            begin
                mul_a = A_W'($signed({1'b0, freq_reg}));
                mul_b = B_W'(bp_cur);
            end
            MUL_SQ:
            begin
                mul_a = A_W'($signed({1'b0, mag}));
                mul_b = B_W'($signed({1'b0, mag}));
            end
            MUL_GAIN:
            begin
                mul_a = $signed({1'b0, level_reg});
                mul_b = B_W'($signed({1'b0, gain_reg}));
            end
            MUL_SMOOTH:
            begin
                mul_a = A_W'($signed({1'b0, c_eff}));
                mul_b = B_W'(smooth_d);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum_add  = {1'b0, sum_reg} + (SUMSQ_W+1)'(prod_reg[2*MAG_W-1:0]);
    assign div_tr   = {rem_reg, q_reg[SUMSQ_W-1]};
    assign div_bit  = div_tr >= {1'b0, count_reg};
    assign sq_tr    = {srem_reg, rad_reg[SUMSQ_W-1 -: 2]};
    assign sq_trial = (SREM_W+2)'({root_reg, 2'b01});
    assign sq_bit   = sq_tr >= sq_trial;
    assign gain_sh  = prod_reg[P_W-1:16];
    assign outv     = smoothed_reg[SMOOTH_W-1:15];
    assign need     = (frames_cfg_reg == '0) ? 20'd1 : frames_cfg_reg;
    assign send_now = rate_reg ? (!emitted_reg || frames_reg >= {1'b0, need})
                               : (!emitted_reg || outv != last_emit_reg);
    assign filt_clear = cfg_we && (cfg_index == CFG_FREQ || cfg_index == CFG_DAMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_en_reg      <= RST_BAND_EN;
            peak_sel_reg     <= RST_PEAK_SEL;
            freq_reg         <= RST_FREQ;
            damp_reg         <= RST_DAMP;
            gain_reg         <= RST_GAIN;
            smooth_coeff_reg <= RST_SMOOTH;
            rate_reg         <= RST_RATE;
            frames_cfg_reg   <= RST_FRAMES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAND_EN:   band_en_reg      <= cfg_data[0];
                CFG_PEAK_SEL:  peak_sel_reg     <= cfg_data[0];
                CFG_FREQ:      freq_reg         <= cfg_data[17:0];
                CFG_DAMP:      damp_reg         <= cfg_data[23:0];
                CFG_GAIN:      gain_reg         <= cfg_data[25:0];
                CFG_SMOOTH:    smooth_coeff_reg <= cfg_data[16:0];
                CFG_RATE_MODE: rate_reg         <= cfg_data[0];
                CFG_FRAMES:    frames_cfg_reg   <= cfg_data[19:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_l_reg <= '0;
            bp_l_reg <= '0;
            lp_r_reg <= '0;
            bp_r_reg <= '0;
        end
        else if (filt_clear)
        begin
            lp_l_reg <= '0;
            bp_l_reg <= '0;
            lp_r_reg <= '0;
            bp_r_reg <= '0;
        end
        else
        begin
            if (cmd.upd_bp && !cmd.ch)
            begin
                bp_l_reg <= bp_new;
            end
            if (cmd.upd_bp && cmd.ch)
            begin
                bp_r_reg <= bp_new;
            end
            if (cmd.upd_lp && !cmd.ch)
            begin
                lp_l_reg <= lp_new;
            end
            if (cmd.upd_lp && cmd.ch)
            begin
                lp_r_reg <= lp_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            smoothed_reg  <= '0;
            frames_reg    <= '0;
            last_emit_reg <= '0;
            emitted_reg   <= 1'b0;
            send_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc && count_reg < CNT_LIMIT)
            begin
                sum_reg   <= sum_add[SUMSQ_W] ? '1 : sum_add[SUMSQ_W-1:0];
                peak_reg  <= (mag > peak_reg) ? mag : peak_reg;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.frame_tick && rate_reg && frames_reg != '1)
            begin
                frames_reg <= frames_reg + 1'b1;
            end
            if (cmd.smooth_inst)
            begin
                smoothed_reg <= {target_reg, 15'b0};
            end
            if (cmd.smooth_upd)
            begin
                smoothed_reg <= smoothed_reg + prod_sh[SMOOTH_W-1:0];
            end
            if (cmd.decide)
            begin
                send_reg  <= send_now;
                sum_reg   <= '0;
                peak_reg  <= '0;
                count_reg <= '0;
                if (rate_reg && send_now)
                begin
                    frames_reg <= '0;
                end
                if (send_now)
                begin
                    last_emit_reg <= outv;
                    emitted_reg   <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            xl_reg   <= xl_in;
            xr_reg   <= xr_in;
            pl_reg   <= left_present;
            pr_reg   <= right_present;
            last_reg <= last_in_block;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= P_W'(mul_a) * P_W'(mul_b);
        end
        if (cmd.upd_h)
        begin
            h_reg <= hp_new;
        end
        if (cmd.div_init)
        begin
            q_reg   <= sum_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            q_reg   <= {q_reg[SUMSQ_W-2:0], div_bit};
            rem_reg <= div_bit ? CNT_W'(div_tr - {1'b0, count_reg}) : div_tr[CNT_W-1:0];
        end
        if (cmd.root_init)
        begin
            rad_reg  <= q_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SUMSQ_W-3:0], 2'b00};
            srem_reg <= sq_bit ? SREM_W'(sq_tr - sq_trial) : sq_tr[SREM_W-1:0];
            root_reg <= {root_reg[LEVEL_W-2:0], sq_bit};
        end
        if (cmd.lvl_peak)
        begin
            level_reg <= LEVEL_W'(peak_reg);
        end
        if (cmd.lvl_zero)
        begin
            level_reg <= '0;
        end
        if (cmd.lvl_root)
        begin
            level_reg <= root_reg;
        end
        if (cmd.clamp)
        begin
            target_reg <= (gain_sh > (P_W-16)'(LEVEL_ONE)) ? LEVEL_ONE : gain_sh[16:0];
        end
        if (cmd.load_out)
        begin
            out_level_reg <= outv;
        end
    end

    assign st.cur_present = cmd.ch ? pr_reg : pl_reg;
    assign st.filt_en     = band_en_reg;
    assign st.last        = last_reg;
    assign st.peak_sel    = peak_sel_reg;
    assign st.count_zero  = (count_reg == '0);
    assign st.smooth_inst = (c_eff == LEVEL_ONE);
    assign st.send        = send_reg;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign level_value = out_level_reg;

endmodule
`default_nettype wire

### design/band_level_meter_event_emitter_core.sv
// Band level meter. Each input item is one stereo frame; each present channel
// is optionally bandpass filtered and accumulated into the block's sum of
// squares, count and peak. The frame marked last in block forms the RMS or
// peak level, applies gain, clamp and one-pole smoothing, and may emit one
// result item on the output channel.
// With filtering on, each present channel runs three filter multiply and
// update steps before its square step; every filter and square step goes
// through one shared multiplier. A last frame also applies gain, clamp and
// smoothing on that multiplier, and in RMS mode first runs the 56-step
// restoring divider and the 28-step square root.
// The block works on one item at a time and takes the next item as soon as
// the previous one is finished, even while its result still waits in the
// output register. A stalled receiver only holds back the block when a new
// result is ready and the output register is still full.
// Configuration writes are taken in any cycle and take effect at once, so
// they belong between items while nothing is in flight; writing either
// filter coefficient clears the filter state.
// Reset loads the default configuration and clears all filter, block and
// emission state; no clearing pass is needed.
`default_nettype none
module band_level_meter_event_emitter_core
    import blmee_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    input  wire logic                          left_present,
    input  wire logic                          right_present,
    input  wire logic                          last_in_block,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [OUT_W-1:0]                   level_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    blmee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    blmee_dp #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .left_present  (left_present),
        .right_present (right_present),
        .last_in_block (last_in_block),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level_value   (level_value)
    );

endmodule
`default_nettype wire
